// ===== rtl/scs_pkg.sv =====
// Shared types and constants for the sidechain curve sequencer.
// No dependencies; imported by the top level and scs_ctrl.
package scs_pkg;

  localparam int REQ_W       = 2;
  localparam int CHANNEL_W   = 4;
  localparam int NOTE_W      = 7;
  localparam int POINT_IDX_W = 6;
  localparam int LEVEL_W     = 7;
  localparam int DELAY_W     = 16;
  localparam int DEPTH_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;
  // offset used when depth is zero (no ducking)
  localparam logic [LEVEL_W:0]   OFFSET_NONE = 8'd127;
  localparam int                 OFFSET_SHIFT = 3;  // depth step of 8

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_NOTE_ON = 2'd1,
    REQ_WRITE   = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_CHANNEL = 3'd0,
    CFG_TRIG_NOTE   = 3'd1,
    CFG_ENABLE      = 3'd2,
    CFG_TICK_GAP    = 3'd3,
    CFG_DEPTH       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] src_channel;
    logic [NOTE_W-1:0]    trig_note;
    logic                 enable;
    logic [DELAY_W-1:0]   tick_gap;
    logic [DEPTH_W-1:0]   depth;
  } cfg_t;

  // item held in the execute stage
  typedef struct packed {
    req_t                 req;
    logic [CHANNEL_W-1:0] channel;
    logic [NOTE_W-1:0]    note;
  } ev_t;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
    logic               busy;
  } res_t;

endpackage

// ===== rtl/sidechain_curve_sequencer.sv =====
// Sidechain ducking curve sequencer, top level.
// Depends on scs_pkg, scs_ram and scs_ctrl.
//
// The block takes one item per clock unless stalled: curve point writes,
// note-on events and ticks. A matching note-on starts the curve and
// returns its first point; ticks count down the step delay and, on expiry,
// return the next point, then one final 127 that clears busy_flag. The
// pipeline is input stage (curve RAM access at the accepting edge) ->
// execute stage -> output register, and the sustained rate is one item per
// cycle while out_stall stays low. The curve RAM has a single port shared
// by writes and reads; the position for a tick's read is forwarded from
// the execute stage so ticks may follow each other directly. Curve entries
// are undefined until written; there is no clearing pass after reset.
module sidechain_curve_sequencer #(
  parameter int CURVE_LEN = 64,
  parameter int MAX_DEPTH = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [scs_pkg::REQ_W-1:0]         in_req_type,
  input  logic [scs_pkg::CHANNEL_W-1:0]     in_channel,
  input  logic [scs_pkg::NOTE_W-1:0]        in_note,
  input  logic [scs_pkg::POINT_IDX_W-1:0]   in_point_index,
  input  logic [scs_pkg::LEVEL_W-1:0]       in_point_value,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [scs_pkg::LEVEL_W-1:0]       out_level,
  output logic                              out_busy_flag
);
  import scs_pkg::*;

  localparam int AW = $clog2(CURVE_LEN);
  localparam int PW = $clog2(CURVE_LEN + 2);

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_channel <= '0;
      cfg_r.trig_note   <= '0;
      cfg_r.enable      <= 1'b1;
      cfg_r.tick_gap    <= '0;
      cfg_r.depth       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SRC_CHANNEL: cfg_r.src_channel <= cfg_data[CHANNEL_W-1:0];
        CFG_TRIG_NOTE:   cfg_r.trig_note   <= cfg_data[NOTE_W-1:0];
        CFG_ENABLE:      cfg_r.enable      <= cfg_data[0];
        CFG_TICK_GAP:    cfg_r.tick_gap    <= cfg_data[DELAY_W-1:0];
        CFG_DEPTH:       cfg_r.depth       <= cfg_data[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake and stage control
  logic          s1_valid_r;
  ev_t           s1_ev_r;
  logic          out_free;
  logic          s1_fire;
  logic          in_acc;
  res_t          res;
  logic [PW-1:0] rd_pos;

  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_busy_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // curve RAM: writes and reads both happen as the item is accepted
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [LEVEL_W-1:0] ram_rdata;

  always_comb begin
    ram_we   = in_acc && (req_t'(in_req_type) == REQ_WRITE)
               && (int'(in_point_index) < CURVE_LEN);
    ram_addr = AW'(rd_pos);
    case (req_t'(in_req_type))
      REQ_WRITE:   ram_addr = AW'(in_point_index);
      REQ_NOTE_ON: ram_addr = '0;
      default:     ram_addr = AW'(rd_pos);
    endcase
  end

  scs_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (CURVE_LEN)
  ) u_curve_ram (
    .clk   (clk),
    .en    (in_acc),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_point_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ev_r.req     <= req_t'(in_req_type);
      s1_ev_r.channel <= in_channel;
      s1_ev_r.note    <= in_note;
    end
  end

  scs_ctrl #(
    .CURVE_LEN (CURVE_LEN),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .ev      (s1_ev_r),
    .cfg     (cfg_r),
    .rd_data (ram_rdata),
    .res     (res),
    .rd_pos  (rd_pos)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_level_r <= res.level;
      out_busy_r  <= res.busy;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_level_r;
  assign out_busy_flag = out_busy_r;

endmodule

// ===== rtl/scs_ram.sv =====
// Generic single-port RAM, synchronous write, registered read.
// No dependencies.
module scs_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/scs_ctrl.sv =====
// Execute stage: playback position, step delay counter, busy flag and
// level computation from the curve RAM read data. Depends on scs_pkg.
module scs_ctrl #(
  parameter int CURVE_LEN = 64,
  parameter int MAX_DEPTH = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  scs_pkg::ev_t                        ev,
  input  scs_pkg::cfg_t                       cfg,
  input  logic [scs_pkg::LEVEL_W-1:0]         rd_data,
  output scs_pkg::res_t                       res,
  output logic [$clog2(CURVE_LEN+2)-1:0]      rd_pos
);
  import scs_pkg::*;

  localparam int PW = $clog2(CURVE_LEN + 2);
  localparam logic [PW-1:0]        POS_END   = PW'(CURVE_LEN);
  localparam logic [PW-1:0]        POS_IDLE  = PW'(CURVE_LEN + 1);
  localparam logic [DEPTH_W-1:0]   DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [LEVEL_W:0]     DEPTH_TOP = (LEVEL_W + 1)'(MAX_DEPTH + 1);

  logic [PW-1:0]      pos_r, pos_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic               busy_r, busy_nxt;

  logic [DEPTH_W-1:0] depth_c;
  logic [LEVEL_W:0]   offset;
  logic [LEVEL_W:0]   sum;
  logic [LEVEL_W-1:0] point_level;

  // curve point through the depth offset, saturating at full scale
  always_comb begin
    depth_c = (cfg.depth > DEPTH_MAX) ? DEPTH_MAX : cfg.depth;
    if (depth_c == '0) begin
      offset = OFFSET_NONE;
    end else begin
      offset = (DEPTH_TOP - {{(LEVEL_W + 1 - DEPTH_W){1'b0}}, depth_c}) << OFFSET_SHIFT;
    end
    sum = {1'b0, rd_data} + offset;
    if (!cfg.enable || sum > {1'b0, LEVEL_MAX}) begin
      point_level = LEVEL_MAX;
    end else begin
      point_level = sum[LEVEL_W-1:0];
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    delay_nxt = delay_r;
    busy_nxt  = busy_r;
    res.valid = 1'b0;
    res.level = point_level;
    case (ev.req)
      REQ_NOTE_ON: begin
        if (ev.channel == cfg.src_channel && ev.note == cfg.trig_note) begin
          pos_nxt   = '0;
          delay_nxt = cfg.tick_gap;
          busy_nxt  = 1'b1;
          res.valid = 1'b1;
        end
      end
      REQ_TICK: begin
        if (delay_r != '0) begin
          delay_nxt = delay_r - 1'b1;
        end else begin
          delay_nxt = cfg.tick_gap;
          if (pos_r < POS_END) begin
            res.valid = 1'b1;
            // full-scale point ends the curve early
            pos_nxt = (point_level == LEVEL_MAX) ? POS_END : pos_r + 1'b1;
          end else if (pos_r == POS_END) begin
            res.valid = 1'b1;
            res.level = LEVEL_MAX;
            busy_nxt  = 1'b0;
            delay_nxt = '0;
            pos_nxt   = POS_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
    res.valid = res.valid & fire;
    res.busy  = busy_nxt;
  end

  // forward the updated position to the read issued this cycle
  assign rd_pos = fire ? pos_nxt : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_IDLE;
      delay_r <= '0;
      busy_r  <= 1'b0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      delay_r <= delay_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// ===== tb/scs_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the sidechain curve sequencer: tracks register writes and accepted
// items, predicts each ducked level and compares it with the result channel.
// Depends on scs_pkg only.
module scs_checker #(
  parameter int CURVE_LEN = 64,
  parameter int MAX_DEPTH = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [scs_pkg::REQ_W-1:0]       in_req_type,
  input  logic [scs_pkg::CHANNEL_W-1:0]   in_channel,
  input  logic [scs_pkg::NOTE_W-1:0]      in_note,
  input  logic [scs_pkg::POINT_IDX_W-1:0] in_point_index,
  input  logic [scs_pkg::LEVEL_W-1:0]     in_point_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [scs_pkg::LEVEL_W-1:0]     out_level,
  input  logic                            out_busy_flag,
  output int                              mismatches = 0,
  output int                              pending = 0
);
  import scs_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               busy;
  } duck_t;

  cfg_t               regs;
  logic [LEVEL_W-1:0] curve_pts [CURVE_LEN];
  int unsigned        position;
  logic [DELAY_W-1:0] delay_count;
  logic               playing;
  duck_t              duck_q [$];

  // curve point seen through the depth offset, saturated at full level
  function automatic logic [LEVEL_W-1:0] ducked_level(int unsigned idx);
    int unsigned d;
    int unsigned off;
    int unsigned sum;
    if (!regs.enable || idx >= CURVE_LEN) return LEVEL_MAX;
    d = regs.depth;
    if (d > MAX_DEPTH) d = MAX_DEPTH;
    off = (d > 0) ? (MAX_DEPTH + 1 - d) << OFFSET_SHIFT : OFFSET_NONE;
    sum = curve_pts[idx] + off;
    return (sum > LEVEL_MAX) ? LEVEL_MAX : sum[LEVEL_W-1:0];
  endfunction

  task automatic advance_envelope(input logic [REQ_W-1:0] req,
                                  input logic [CHANNEL_W-1:0] ch,
                                  input logic [NOTE_W-1:0] note,
                                  input logic [POINT_IDX_W-1:0] idx,
                                  input logic [LEVEL_W-1:0] val);
    duck_t r;
    case (req)
      REQ_WRITE: begin
        if (idx < CURVE_LEN) curve_pts[idx] = val;
      end
      REQ_NOTE_ON: begin
        if (ch == regs.src_channel && note == regs.trig_note) begin
          position    = 0;
          delay_count = regs.tick_gap;
          playing     = 1'b1;
          r.level     = ducked_level(0);
          r.busy      = 1'b1;
          duck_q.push_back(r);
        end
      end
      REQ_TICK: begin
        if (delay_count > 0) begin
          delay_count = delay_count - 1'b1;
        end else begin
          delay_count = regs.tick_gap;
          if (position < CURVE_LEN) begin
            r.level  = ducked_level(position);
            // a full-level point cuts the curve short
            position = (r.level == LEVEL_MAX) ? CURVE_LEN : position + 1;
            r.busy   = playing;
            duck_q.push_back(r);
          end else if (position == CURVE_LEN) begin
            // closing full level, LED off, back to idle
            playing     = 1'b0;
            delay_count = '0;
            position    = CURVE_LEN + 1;
            r.level     = LEVEL_MAX;
            r.busy      = 1'b0;
            duck_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    duck_t want;
    if (!rst_n) begin
      regs             = '0;
      regs.enable      = 1'b1;
      position         = CURVE_LEN + 1;
      delay_count      = '0;
      playing          = 1'b0;
      duck_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_CHANNEL: regs.src_channel = cfg_data[CHANNEL_W-1:0];
          CFG_TRIG_NOTE:   regs.trig_note   = cfg_data[NOTE_W-1:0];
          CFG_ENABLE:      regs.enable      = cfg_data[0];
          CFG_TICK_GAP:    regs.tick_gap    = cfg_data[DELAY_W-1:0];
          CFG_DEPTH:       regs.depth       = cfg_data[DEPTH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        advance_envelope(in_req_type, in_channel, in_note, in_point_index, in_point_value);
      if (out_valid && !out_stall) begin
        if (duck_q.size() == 0) begin
          $error("unexpected result: level %0d busy_flag %0d", out_level, out_busy_flag);
          mismatches++;
        end else begin
          want = duck_q.pop_front();
          if (out_level !== want.level) begin
            $error("level expected %0d actual %0d", want.level, out_level);
            mismatches++;
          end
          if (out_busy_flag !== want.busy) begin
            $error("busy_flag expected %0d actual %0d", want.busy, out_busy_flag);
            mismatches++;
          end
        end
      end
    end
    pending <= duck_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the sidechain curve sequencer testbench: clock, reset, register setup, item
// stimulus and the verdict. Depends on scs_pkg, the block and scs_checker.
module tb;
  import scs_pkg::*;

  localparam int CURVE_LEN = 64;
  localparam int MAX_DEPTH = 15;
  localparam int LIMIT     = 200000;   // cycles before the run is declared hung
  localparam int PHASE_ITEMS = 30;     // state-changing items per random phase
  localparam int PHASES    = 6;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [REQ_W-1:0]       in_req_type = '0;
  logic [CHANNEL_W-1:0]   in_channel = '0;
  logic [NOTE_W-1:0]      in_note = '0;
  logic [POINT_IDX_W-1:0] in_point_index = '0;
  logic [LEVEL_W-1:0]     in_point_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [LEVEL_W-1:0]     out_level;
  logic                   out_busy_flag;
  int                     mismatches;
  int                     pending;

  int   cycle = 0;
  int   useful = 0;      // items that change block state (ignored ones don't count)
  logic steady = 1'b0;   // both sides run without gaps or stalls while set
  cfg_t cur;             // register values currently loaded

  sidechain_curve_sequencer #(.CURVE_LEN(CURVE_LEN), .MAX_DEPTH(MAX_DEPTH)) DUT (.*);
  scs_checker #(.CURVE_LEN(CURVE_LEN), .MAX_DEPTH(MAX_DEPTH)) checker_i (.*);

  always #4 clk = ~clk;

  // hung-run guard
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure; about a quarter of cycles stalled outside the steady stretch
  always @(posedge clk) begin
    if (steady) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(0, 99) < 26);
  end

  // Present one item and hold it until accepted. in_valid is only lowered when a
  // gap is taken, so back-to-back items never see a low/high pair in one step.
  task automatic send_item(input logic [REQ_W-1:0] req, input int ch, input int note,
                           input int idx, input int val);
    if (!steady && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 26);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_channel     <= CHANNEL_W'(ch);
    in_note        <= NOTE_W'(note);
    in_point_index <= POINT_IDX_W'(idx);
    in_point_value <= LEVEL_W'(val);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req == REQ_TICK || req == REQ_WRITE ||
        (req == REQ_NOTE_ON && ch == cur.src_channel && note == cur.trig_note))
      useful++;
  endtask

  // don't-care fields on ticks are randomized to keep the bits moving
  task automatic tick();
    send_item(REQ_TICK, $urandom_range(0, 15), $urandom_range(0, 127),
              $urandom_range(0, 63), $urandom_range(0, 127));
  endtask

  task automatic note_on(input int ch, input int note);
    send_item(REQ_NOTE_ON, ch, note, $urandom_range(0, 63), $urandom_range(0, 127));
  endtask

  task automatic write_point(input int idx, input int val);
    send_item(REQ_WRITE, $urandom_range(0, 15), $urandom_range(0, 127), idx, val);
  endtask

  // Wait until every expected result is back, then let a possible result-less
  // item still in the two-stage pipe drain out.
  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // registers are only touched with the block drained
  task automatic load_regs(input cfg_t c);
    drain_block();
    write_reg(CFG_SRC_CHANNEL, CFG_DATA_W'(c.src_channel));
    write_reg(CFG_TRIG_NOTE,   CFG_DATA_W'(c.trig_note));
    write_reg(CFG_ENABLE,      CFG_DATA_W'(c.enable));
    write_reg(CFG_TICK_GAP,    c.tick_gap);
    write_reg(CFG_DEPTH,       CFG_DATA_W'(c.depth));
    cfg_we <= 1'b0;
    cur = c;
  endtask

  function automatic cfg_t random_regs(int phase);
    cfg_t c;
    c.src_channel = CHANNEL_W'($urandom_range(0, 15));
    c.trig_note   = NOTE_W'($urandom_range(0, 127));
    c.enable      = ($urandom_range(0, 9) != 0);
    c.tick_gap    = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 4));
    c.depth       = DEPTH_W'($urandom_range(0, 15));
    if (phase == 0) c.enable = 1'b0;          // every point reads as full level
    if (phase == 1) begin                     // slowest delay, no ducking
      c.tick_gap = 16'hFFFF;
      c.depth    = '0;
    end
    return c;
  endfunction

  // Ignored or off-target items: unused request type, stray note-ons, random
  // writes and ticks.
  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: send_item(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 127),
                   $urandom_range(0, 63), $urandom_range(0, 127));
      1: note_on($urandom_range(0, 15), $urandom_range(0, 127));
      2: write_point($urandom_range(0, 63), $urandom_range(0, 127));
      default: tick();
    endcase
  endtask

  // One well-formed playback: optionally a fresh short curve ending in a full-level
  // point, the trigger, then a run of ticks capped at 40 items, with a little noise.
  task automatic play_curve();
    int i;
    int stop_at;
    int n;
    if ($urandom_range(0, 1)) begin
      stop_at = $urandom_range(1, 6);
      for (i = 0; i < stop_at; i++) write_point(i, $urandom_range(0, 126));
      write_point(stop_at, LEVEL_MAX);
    end else begin
      stop_at = 8;
    end
    note_on(cur.src_channel, cur.trig_note);
    n = (stop_at + 2) * (cur.tick_gap + 1) + $urandom_range(0, 3);
    if (n > 40) n = $urandom_range(4, 40);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0:       noise_item();
        1:       write_point($urandom_range(0, 7), $urandom_range(0, 127));
        2:       note_on(cur.src_channel, cur.trig_note);   // restart mid-curve
        default: tick();
      endcase
    end
  endtask

  initial begin
    cfg_t c;
    int   i;
    int   p;
    int   mark;

    cur = '0;
    cur.enable = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole curve first: entries read before being written are undefined.
    for (i = 0; i < CURVE_LEN; i++) write_point(i, $urandom_range(0, 127));

    // Directed: deepest ducking (offset 8), no delay, trigger on channel 0 note 0.
    c = '{src_channel: 4'd0, trig_note: 7'd0, enable: 1'b1, tick_gap: 16'd0, depth: 4'd15};
    load_regs(c);
    write_point(0, 0);
    write_point(CURVE_LEN - 1, LEVEL_MAX);
    write_point(1, 119);                      // 119 + 8 saturates: curve ends early
    send_item(REQ_UNUSED, 15, 127, 63, 127);  // unused request type
    note_on(0, 1);                            // note mismatch
    note_on(15, 0);                           // channel mismatch
    note_on(0, 0);                            // trigger: point 0
    tick();                                   // point 0 again on first expiry
    tick();                                   // full level, curve cut short
    tick();                                   // closing full level, LED off
    tick();                                   // idle, no result
    write_point(1, 50);
    note_on(0, 0);
    tick();
    note_on(0, 0);                            // retrigger while playing
    tick();
    tick();

    // Directed: shallowest ducking (offset 120), step delay, top channel and note.
    c = '{src_channel: 4'd15, trig_note: 7'd127, enable: 1'b1, tick_gap: 16'd3,
          depth: 4'd1};
    load_regs(c);
    note_on(15, 127);
    for (i = 0; i < 13; i++) tick();

    // Full-length curve: no point saturates, so all points play through.
    c = '{src_channel: 4'($urandom_range(0, 15)), trig_note: 7'($urandom_range(0, 127)),
          enable: 1'b1, tick_gap: 16'd0, depth: 4'd15};
    load_regs(c);
    for (i = 0; i < CURVE_LEN; i++) write_point(i, $urandom_range(0, 118));
    note_on(cur.src_channel, cur.trig_note);
    for (i = 0; i < CURVE_LEN + 2; i++) tick();

    // Random phases, each with its own register set; phase 2 runs gap-free.
    for (p = 0; p < PHASES; p++) begin
      load_regs(random_regs(p));
      steady = (p == 2);
      mark = useful;
      while (useful - mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) noise_item();
        else                           play_curve();
      end
    end
    steady = 1'b0;

    drain_block();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else                 $display("Mismatches found");
    $finish;
  end

endmodule
